### rtl/dppd_pkg.sv
`default_nettype none

package dppd_pkg;

    // input item selector carried in tuser
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_DECODE = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_OVERRUN = 2'd2;
    localparam logic [1:0] STAT_STOPPED = 2'd3;

    // register indexes on the apb port
    localparam logic [2:0] REG_INTER  = 3'd0;
    localparam logic [2:0] REG_TABLE  = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_BASE   = 3'd4;

    localparam logic [9:0]  MAX_ROW_PAIRS = 10'd512;
    localparam logic [10:0] MAX_ROWS      = 11'd1024;
    localparam logic [7:0]  LAST_CODE     = 8'd144;
    localparam logic [7:0]  RUN_BIAS      = 8'd127;
    localparam logic [7:0]  MID_GRAY      = 8'h80;

    localparam int FRAME_PAIRS = 65536;
    localparam int TABLE_BYTES = 1024;

    typedef struct packed {
        logic [7:0]        base_even;
        logic [7:0]        base_odd;
        logic signed [8:0] delta_even;
        logic signed [8:0] delta_odd;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] pix_even;
        logic [7:0] pix_odd;
    } t_alu_out;

    // table byte to signed delta; inter scales by 3/4 with floor
    function automatic logic signed [8:0] delta_of(input logic [7:0] e, input logic inter);
        logic [9:0] t3;
        t3 = {2'b00, e} + {1'b0, e, 1'b0};
        if (inter) begin
            return $signed({1'b0, t3[9:2]}) - 9'sd96;
        end
        return $signed({1'b0, e}) - 9'sd128;
    endfunction

endpackage

`default_nettype wire

### rtl/dppd_pair_alu.sv
`default_nettype none

module dppd_pair_alu
    import dppd_pkg::*;
(
    input  t_alu_in  i_op,
    output t_alu_out o_res
);

    function automatic logic [7:0] clip_add(input logic [7:0] b, input logic signed [8:0] d);
        logic signed [9:0] s;
        s = $signed({2'b00, b}) + $signed({d[8], d});
        if (s < 10'sd0) begin
            return 8'd0;
        end
        if (s > 10'sd255) begin
            return 8'd255;
        end
        return s[7:0];
    endfunction

    assign o_res.pix_even = clip_add(i_op.base_even, i_op.delta_even);
    assign o_res.pix_odd  = clip_add(i_op.base_odd, i_op.delta_odd);

endmodule

`default_nettype wire

### rtl/delta_pair_plane_decoder.sv
// two-pixel dpcm / run-length plane decoder
// slave stream: tuser = func (start plane, load table byte, decode code);
//   tdata = code, table_address, table_value. one transaction per item.
// master stream: tdata = pair_address, pixel_even, pixel_odd; tuser = status,
//   plane_done; tlast marks the last result of a code.
// apb port holds inter_mode, table_select, width_pairs, plane_height,
//   plane_base at byte addresses 0,4,8,12,16; start plane latches them.
// steps: start, load and no-op finish in the idle state. a delta code passes
//   two table byte read states, one store read and one store write with result.
//   a run of n pairs goes pair by pair: a store read state, then a write state,
//   all through the single pair alu, which adds both pixels side by side.
//   stopped, invalid and overrun codes give one result from the error state.
// one result register feeds the master side; a stalled receiver holds the
//   sequencer in its write or error state, and a new item is taken while the last
//   result waits. tready is high only while the sequencer is idle.
// reset leaves the block stopped (decodes give status stopped) until a start
//   plane with good geometry; frame store and tables are not cleared.
`default_nettype none

module delta_pair_plane_decoder
    import dppd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // code[7:0], table_address[17:8], table_value[25:18]
    input  wire logic [1:0]  i_s_tuser,   // func[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // pair_address[15:0], pixel_even[23:16], pixel_odd[31:24]
    output logic [2:0]       o_m_tuser,   // status[1:0], plane_done[2]
    output logic             o_m_tlast,   // run_last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [2:0] {ST_IDLE, ST_TAB0, ST_TAB1, ST_RD, ST_WR, ST_ERR} t_state;

    t_state r_state;

    logic        r_cfg_inter;
    logic [1:0]  r_cfg_table;
    logic [9:0]  r_cfg_width;
    logic [10:0] r_cfg_height;
    logic [15:0] r_cfg_base;

    logic        r_act_inter;
    logic [1:0]  r_act_table;
    logic [9:0]  r_act_width;
    logic [10:0] r_act_height;

    logic [9:0]  r_col;
    logic [10:0] r_row;
    logic [15:0] r_row_base;
    logic [15:0] r_above_base;
    logic        r_stopped;

    logic [6:0]        r_code;
    logic              r_is_run;
    logic [4:0]        r_cnt;
    logic signed [8:0] r_de;
    logic signed [8:0] r_do;
    logic [15:0]       r_wr_addr;
    logic [1:0]        r_err_status;

    logic [7:0]  r_tab_q;
    logic [15:0] r_fs_q;

    logic        r_m_valid;
    logic [15:0] r_m_addr;
    logic [7:0]  r_m_even;
    logic [7:0]  r_m_odd;
    logic [1:0]  r_m_status;
    logic        r_m_last;
    logic        r_m_done;

    logic [7:0]  r_tables [TABLE_BYTES];
    logic [15:0] r_store  [FRAME_PAIRS];

    // input fields
    logic [1:0] w_func;
    logic [7:0] w_code;
    logic [9:0] w_tab_addr;
    logic [7:0] w_tab_val;
    logic       w_in_acc;

    assign w_func     = i_s_tuser;
    assign w_code     = i_s_tdata[7:0];
    assign w_tab_addr = i_s_tdata[17:8];
    assign w_tab_val  = i_s_tdata[25:18];
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // code classification at accept
    logic        w_invalid;
    logic [7:0]  w_run_diff;
    logic [4:0]  w_n_full;
    logic [10:0] w_col_end;
    logic        w_over;
    logic [9:0]  w_rest;

    assign w_invalid  = (w_code == 8'd0) || (w_code > LAST_CODE);
    assign w_run_diff = w_code - RUN_BIAS;
    assign w_n_full   = w_code[7] ? w_run_diff[4:0] : 5'd1;
    assign w_col_end  = {1'b0, r_col} + {6'd0, w_n_full};
    assign w_over     = w_code[7] && (w_col_end > {1'b0, r_act_width});
    assign w_rest     = r_act_width - r_col;

    logic w_bad_geom;
    assign w_bad_geom = (r_cfg_width == 10'd0) || (r_cfg_width > MAX_ROW_PAIRS) ||
                        (r_cfg_height == 11'd0) || (r_cfg_height > MAX_ROWS);

    // pair step
    logic        w_out_free;
    logic        w_emit;
    logic [10:0] w_col_next;
    logic [10:0] w_row_next;
    logic        w_row_end;
    logic        w_plane_end;
    logic        w_last;
    logic [15:0] w_rd_addr;

    assign w_out_free  = !r_m_valid || i_m_tready;
    assign w_emit      = w_out_free && ((r_state == ST_WR) || (r_state == ST_ERR));
    assign w_col_next  = {1'b0, r_col} + 11'd1;
    assign w_row_next  = r_row + 11'd1;
    assign w_row_end   = (w_col_next >= {1'b0, r_act_width});
    assign w_plane_end = (w_row_next >= r_act_height);
    assign w_last      = (r_cnt == 5'd1);
    assign w_rd_addr   = (r_act_inter ? r_row_base : r_above_base) + {6'd0, r_col};

    t_alu_in  w_alu_in;
    t_alu_out w_alu_out;

    always_comb begin
        if (!r_act_inter && (r_row == 11'd0)) begin
            w_alu_in.base_even = MID_GRAY;
            w_alu_in.base_odd  = MID_GRAY;
        end else begin
            w_alu_in.base_even = r_fs_q[7:0];
            w_alu_in.base_odd  = r_fs_q[15:8];
        end
        w_alu_in.delta_even = r_de;
        w_alu_in.delta_odd  = r_do;
    end

    dppd_pair_alu u_alu (
        .i_op  (w_alu_in),
        .o_res (w_alu_out)
    );

    // table memory
    logic [9:0] w_tab_raddr;
    assign w_tab_raddr = {r_act_table, r_code, (r_state == ST_TAB1)};

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_func == FUNC_LOAD)) begin
            r_tables[w_tab_addr] <= w_tab_val;
        end
        if ((r_state == ST_TAB0) || (r_state == ST_TAB1)) begin
            r_tab_q <= r_tables[w_tab_raddr];
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WR) && w_out_free) begin
            r_store[r_wr_addr] <= {w_alu_out.pix_odd, w_alu_out.pix_even};
        end
        if (r_state == ST_RD) begin
            r_fs_q <= r_store[w_rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_inter  <= 1'b0;
            r_cfg_table  <= 2'd0;
            r_cfg_width  <= 10'd1;
            r_cfg_height <= 11'd1;
            r_cfg_base   <= 16'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_INTER:  r_cfg_inter  <= pwdata[0];
                REG_TABLE:  r_cfg_table  <= pwdata[1:0];
                REG_WIDTH:  r_cfg_width  <= pwdata[9:0];
                REG_HEIGHT: r_cfg_height <= pwdata[10:0];
                REG_BASE:   r_cfg_base   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_INTER:  prdata = {31'd0, r_cfg_inter};
            REG_TABLE:  prdata = {30'd0, r_cfg_table};
            REG_WIDTH:  prdata = {22'd0, r_cfg_width};
            REG_HEIGHT: prdata = {21'd0, r_cfg_height};
            REG_BASE:   prdata = {16'd0, r_cfg_base};
            default:    prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_act_inter  <= 1'b0;
            r_act_table  <= 2'd0;
            r_act_width  <= 10'd1;
            r_act_height <= 11'd1;
            r_col        <= 10'd0;
            r_row        <= 11'd0;
            r_row_base   <= 16'd0;
            r_above_base <= 16'd0;
            r_stopped    <= 1'b1;
            r_cnt        <= 5'd0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_m_tready && !w_emit) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (w_func)
                            FUNC_START: begin
                                r_act_inter  <= r_cfg_inter;
                                r_act_table  <= r_cfg_table;
                                r_act_width  <= r_cfg_width;
                                r_act_height <= r_cfg_height;
                                r_col        <= 10'd0;
                                r_row        <= 11'd0;
                                r_row_base   <= r_cfg_base;
                                r_above_base <= r_cfg_base - {6'd0, r_cfg_width};
                                r_stopped    <= w_bad_geom;
                            end
                            FUNC_DECODE: begin
                                if (r_stopped) begin
                                    r_err_status <= STAT_STOPPED;
                                    r_state      <= ST_ERR;
                                end else if (w_invalid) begin
                                    r_stopped    <= 1'b1;
                                    r_err_status <= STAT_INVALID;
                                    r_state      <= ST_ERR;
                                end else if (w_over && !r_act_inter) begin
                                    r_stopped    <= 1'b1;
                                    r_err_status <= STAT_OVERRUN;
                                    r_state      <= ST_ERR;
                                end else begin
                                    r_code   <= w_code[6:0];
                                    r_is_run <= w_code[7];
                                    r_cnt    <= w_over ? w_rest[4:0] : w_n_full;
                                    if (w_code[7]) begin
                                        r_de    <= 9'sd0;
                                        r_do    <= 9'sd0;
                                        r_state <= ST_RD;
                                    end else begin
                                        r_state <= ST_TAB0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_TAB0: begin
                    r_state <= ST_TAB1;
                end
                ST_TAB1: begin
                    r_de    <= delta_of(r_tab_q, r_act_inter);
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    // odd table byte lands here for delta codes
                    if (!r_is_run) begin
                        r_do <= delta_of(r_tab_q, r_act_inter);
                    end
                    r_wr_addr <= r_row_base + {6'd0, r_col};
                    r_state   <= ST_WR;
                end
                ST_WR: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_addr   <= r_wr_addr;
                        r_m_even   <= w_alu_out.pix_even;
                        r_m_odd    <= w_alu_out.pix_odd;
                        r_m_status <= STAT_OK;
                        r_m_last   <= w_last;
                        r_m_done   <= w_row_end && w_plane_end;
                        if (w_row_end) begin
                            r_col        <= 10'd0;
                            r_row        <= w_row_next;
                            r_above_base <= r_row_base;
                            r_row_base   <= r_row_base + {6'd0, r_act_width};
                            if (w_plane_end) begin
                                r_stopped <= 1'b1;
                            end
                        end else begin
                            r_col <= w_col_next[9:0];
                        end
                        r_cnt   <= r_cnt - 5'd1;
                        r_state <= w_last ? ST_IDLE : ST_RD;
                    end
                end
                ST_ERR: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_addr   <= 16'd0;
                        r_m_even   <= 8'd0;
                        r_m_odd    <= 8'd0;
                        r_m_status <= r_err_status;
                        r_m_last   <= 1'b1;
                        r_m_done   <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_odd, r_m_even, r_m_addr};
    assign o_m_tuser  = {r_m_done, r_m_status};
    assign o_m_tlast  = r_m_last;

    // pair count never runs dry inside the pair loop
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RD) || (r_state == ST_WR)) |-> (r_cnt != 5'd0))
        else $error("pair count zero inside pair loop");

    // while decoding, the column stays inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stopped |-> (r_col < r_act_width))
        else $error("column beyond row width");

    // completing the last row stops the block
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WR) && w_out_free && w_row_end && w_plane_end) |=> r_stopped)
        else $error("plane end did not stop the block");

    // error results are always the only result of their code
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[1:0] != STAT_OK)) |-> o_m_tlast)
        else $error("error result without last flag");

endmodule

`default_nettype wire
